// ----- src/tss_pkg.sv -----
// Shared types, constants and saturating arithmetic helpers for the tridiagonal solver.
package tss_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 24;
    localparam int MAX_ROWS  = 64;
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = 6;
    localparam int CNT_W     = 7;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] q_t;

    // One stored row: super-diagonal, modified pivot and modified right-hand side.
    typedef struct packed {
        q_t upper;
        q_t pivot;
        q_t rhs;
    } row_t;

    typedef struct packed {
        logic ovf;
        q_t   val;
    } sat_t;

    typedef struct packed {
        logic start;
        q_t   num;
        q_t   den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic fault;
        q_t   quot;
    } div_res_t;

    // Product scaled back by the fraction bits, rounded towards minus infinity, saturated.
    function automatic sat_t sat_mul(input logic signed [2*DATA_W-1:0] p);
        logic signed [2*DATA_W-1:0] sh;
        sat_t                       r;
        sh    = p >>> FRAC_BITS;
        r.ovf = (sh[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){sh[2*DATA_W-1]}});
        r.val = r.ovf ? (sh[2*DATA_W-1] ? Q_MIN : Q_MAX) : sh[DATA_W-1:0];
        return r;
    endfunction

    // Exact difference, saturated.
    function automatic sat_t sat_sub(input q_t a, input q_t b);
        logic signed [DATA_W:0] d;
        sat_t                   r;
        d     = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        r.ovf = d[DATA_W] ^ d[DATA_W-1];
        r.val = r.ovf ? (d[DATA_W] ? Q_MIN : Q_MAX) : d[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ----- src/tss_div.sv -----
// Serial restoring divider for scaled fixed-point quotients, one quotient bit per cycle.
module tss_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  tss_pkg::div_req_t req,
    output tss_pkg::div_res_t res
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t                       state_reg;
    logic [tss_pkg::DATA_W:0]      rem_reg;
    logic [tss_pkg::DATA_W-1:0]    lo_reg;
    logic [tss_pkg::DATA_W-1:0]    quo_reg;
    logic [tss_pkg::DATA_W-1:0]    den_reg;
    logic [5:0]                    cnt_reg;
    logic                          neg_reg;
    tss_pkg::div_res_t             res_reg;

    logic [tss_pkg::DATA_W-1:0]    num_abs;
    logic [tss_pkg::DATA_W-1:0]    den_abs;
    logic [2*tss_pkg::DATA_W-1:0]  num_mag;
    logic [tss_pkg::DATA_W:0]      rem_sh;
    logic                          qbit;
    logic [tss_pkg::DATA_W:0]      rem_next;

    always_comb
    begin
        num_abs  = req.num[tss_pkg::DATA_W-1] ? (~req.num + 1'b1) : req.num;
        den_abs  = req.den[tss_pkg::DATA_W-1] ? (~req.den + 1'b1) : req.den;
        num_mag  = {{tss_pkg::DATA_W{1'b0}}, num_abs} << tss_pkg::FRAC_BITS;
        rem_sh   = {rem_reg[tss_pkg::DATA_W-1:0], lo_reg[tss_pkg::DATA_W-1]};
        qbit     = (rem_sh >= {1'b0, den_reg});
        rem_next = qbit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= D_IDLE;
            res_reg.done  <= 1'b0;
            res_reg.fault <= 1'b0;
            res_reg.quot  <= '0;
            rem_reg       <= '0;
            lo_reg        <= '0;
            quo_reg       <= '0;
            den_reg       <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg <= req.num[tss_pkg::DATA_W-1] ^ req.den[tss_pkg::DATA_W-1];
                        den_reg <= den_abs;
                        rem_reg <= {1'b0, num_mag[2*tss_pkg::DATA_W-1:tss_pkg::DATA_W]};
                        lo_reg  <= num_mag[tss_pkg::DATA_W-1:0];
                        quo_reg <= '0;
                        cnt_reg <= '0;
                        if (req.den == '0)
                        begin
                            res_reg.done  <= 1'b1;
                            res_reg.fault <= 1'b1;
                            res_reg.quot  <= req.num[tss_pkg::DATA_W-1] ? tss_pkg::Q_MIN
                                                                          : tss_pkg::Q_MAX;
                        end
                        else if (num_mag[2*tss_pkg::DATA_W-1:tss_pkg::DATA_W] >= den_abs)
                        begin
                            // The quotient cannot fit in 32 bits.
                            res_reg.done  <= 1'b1;
                            res_reg.fault <= 1'b1;
                            res_reg.quot  <= (req.num[tss_pkg::DATA_W-1] ^
                                              req.den[tss_pkg::DATA_W-1]) ? tss_pkg::Q_MIN
                                                                          : tss_pkg::Q_MAX;
                        end
                        else
                        begin
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg <= rem_next;
                    lo_reg  <= {lo_reg[tss_pkg::DATA_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[tss_pkg::DATA_W-2:0], qbit};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(tss_pkg::DATA_W - 1))
                    begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    res_reg.done <= 1'b1;
                    state_reg    <= D_IDLE;
                    if (neg_reg)
                    begin
                        res_reg.fault <= (quo_reg > tss_pkg::Q_MIN);
                        res_reg.quot  <= (quo_reg > tss_pkg::Q_MIN) ? tss_pkg::Q_MIN
                                                                    : (~quo_reg + 1'b1);
                    end
                    else
                    begin
                        res_reg.fault <= quo_reg[tss_pkg::DATA_W-1];
                        res_reg.quot  <= quo_reg[tss_pkg::DATA_W-1] ? tss_pkg::Q_MAX : quo_reg;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

// ----- src/tridiagonal_system_solver_unit.sv -----
// Top level of the tridiagonal solver: row memory, solution memory and the sequencer.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------------------
//  input    | in        | in_valid/in_stall  | sub_diag main_diag super_diag rhs_value last_row
//  output   | out       | out_valid/out_stall| solution row_number final_item fault
//
// The serial divider sets the pace of a row that is not the last; row 0 is stored as it
// arrives, with no elimination.
// The last row adds back substitution, one division per stored row, again paced by
// the divider, followed by the results in turn, which an output stall can hold up.
// Reset clears the control state only; the memories hold nothing meaningful until written.
// While the block works on a row or emits results, in_stall is held high.
module tridiagonal_system_solver_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  sub_diag,
    input  logic signed [31:0]  main_diag,
    input  logic signed [31:0]  super_diag,
    input  logic signed [31:0]  rhs_value,
    input  logic                last_row,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  solution,
    output logic [5:0]          row_number,
    output logic                final_item,
    output logic                fault
);

    typedef enum logic [3:0] {
        S_IDLE, S_EL_CAP, S_EL_DIV, S_EL_MC, S_EL_SC, S_EL_MR, S_EL_SR,
        S_BS_RD, S_BS_CAP, S_BS_MUL, S_BS_SUB, S_BS_GO, S_BS_DIV,
        S_EM_RD, S_EM_LD, S_EM_OUT
    } state_t;

    state_t                           state_reg;
    logic [tss_pkg::CNT_W-1:0]        rows_loaded_reg;
    logic                             fault_reg;
    logic [tss_pkg::ADDR_W-1:0]       idx_reg;
    logic [tss_pkg::ADDR_W-1:0]       top_reg;
    logic                             last_reg;

    // Captured row and working values.
    tss_pkg::q_t                      a_reg;
    tss_pkg::q_t                      b_reg;
    tss_pkg::q_t                      c_reg;
    tss_pkg::q_t                      d_reg;
    tss_pkg::q_t                      k_reg;
    tss_pkg::q_t                      up_reg;
    tss_pkg::q_t                      piv_reg;
    tss_pkg::q_t                      rh_reg;
    tss_pkg::q_t                      pnew_reg;
    tss_pkg::q_t                      s_reg;
    tss_pkg::q_t                      xprev_reg;
    logic signed [63:0]               prod_reg;

    logic                             out_valid_reg;
    tss_pkg::q_t                      solution_reg;
    logic [tss_pkg::ADDR_W-1:0]       row_number_reg;
    logic                             final_item_reg;
    logic                             fault_out_reg;

    // Row memory: one entry per stored row, read data registered.
    tss_pkg::row_t                    row_mem [tss_pkg::DEPTH];
    tss_pkg::row_t                    row_rdata_reg;
    logic                             row_we;
    logic [tss_pkg::ADDR_W-1:0]       row_wa;
    logic [tss_pkg::ADDR_W-1:0]       row_ra;
    tss_pkg::row_t                    row_wd;

    // Solution memory, filled during back substitution and drained to the output.
    tss_pkg::q_t                      x_mem [tss_pkg::DEPTH];
    tss_pkg::q_t                      x_rdata_reg;
    logic                             x_we;

    tss_pkg::div_req_t                div_req;
    tss_pkg::div_res_t                div_res;

    tss_pkg::sat_t                    mul_s;
    tss_pkg::sat_t                    sub_s;
    logic                             accept;
    logic                             full;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign full   = (rows_loaded_reg >= tss_pkg::CNT_W'(tss_pkg::MAX_ROWS));

    always_comb
    begin
        mul_s = tss_pkg::sat_mul(prod_reg);
        priority case (state_reg)
            S_EL_SC:  sub_s = tss_pkg::sat_sub(b_reg, mul_s.val);
            S_EL_SR:  sub_s = tss_pkg::sat_sub(d_reg, mul_s.val);
            default:  sub_s = tss_pkg::sat_sub(rh_reg, mul_s.val);
        endcase
    end

    // Memory port control. Row memory reads and writes never address the same entry in one cycle;
    // the solution memory is read at the entry being written, and that read data is not used then.
    always_comb
    begin
        row_we = 1'b0;
        row_wa = rows_loaded_reg[tss_pkg::ADDR_W-1:0];
        row_wd = '{upper: c_reg, pivot: pnew_reg, rhs: sub_s.val};
        row_ra = idx_reg;
        if (accept && !full && (rows_loaded_reg == '0))
        begin
            row_we = 1'b1;
            row_wd = '{upper: super_diag, pivot: main_diag, rhs: rhs_value};
        end
        else if (state_reg == S_EL_SR)
        begin
            row_we = 1'b1;
        end
        if (state_reg == S_IDLE)
        begin
            row_ra = rows_loaded_reg[tss_pkg::ADDR_W-1:0] - 1'b1;
        end
        x_we = (state_reg == S_BS_DIV) && div_res.done;
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        row_rdata_reg <= row_mem[row_ra];
        if (x_we)
        begin
            x_mem[idx_reg] <= div_res.quot;
        end
        x_rdata_reg <= x_mem[idx_reg];
    end

    always_comb
    begin
        div_req.start = (state_reg == S_EL_CAP) || (state_reg == S_BS_GO);
        div_req.num   = (state_reg == S_EL_CAP) ? a_reg : s_reg;
        div_req.den   = (state_reg == S_EL_CAP) ? row_rdata_reg.pivot : piv_reg;
    end

    tss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rows_loaded_reg <= '0;
            fault_reg       <= 1'b0;
            idx_reg         <= '0;
            top_reg         <= '0;
            last_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        a_reg    <= sub_diag;
                        b_reg    <= main_diag;
                        c_reg    <= super_diag;
                        d_reg    <= rhs_value;
                        last_reg <= last_row;
                        if (full)
                        begin
                            // Excess row: dropped, flagged.
                            fault_reg <= 1'b1;
                            if (last_row)
                            begin
                                top_reg   <= tss_pkg::ADDR_W'(tss_pkg::MAX_ROWS - 1);
                                idx_reg   <= tss_pkg::ADDR_W'(tss_pkg::MAX_ROWS - 1);
                                state_reg <= S_BS_RD;
                            end
                        end
                        else if (rows_loaded_reg == '0)
                        begin
                            rows_loaded_reg <= tss_pkg::CNT_W'(1);
                            if (last_row)
                            begin
                                top_reg   <= '0;
                                idx_reg   <= '0;
                                state_reg <= S_BS_RD;
                            end
                        end
                        else
                        begin
                            state_reg <= S_EL_CAP;
                        end
                    end
                end
                S_EL_CAP:
                begin
                    up_reg    <= row_rdata_reg.upper;
                    rh_reg    <= row_rdata_reg.rhs;
                    state_reg <= S_EL_DIV;
                end
                S_EL_DIV:
                begin
                    if (div_res.done)
                    begin
                        k_reg     <= div_res.quot;
                        fault_reg <= fault_reg | div_res.fault;
                        state_reg <= S_EL_MC;
                    end
                end
                S_EL_MC:
                begin
                    prod_reg  <= 64'(k_reg) * 64'(up_reg);
                    state_reg <= S_EL_SC;
                end
                S_EL_SC:
                begin
                    pnew_reg  <= sub_s.val;
                    fault_reg <= fault_reg | mul_s.ovf | sub_s.ovf;
                    state_reg <= S_EL_MR;
                end
                S_EL_MR:
                begin
                    prod_reg  <= 64'(k_reg) * 64'(rh_reg);
                    state_reg <= S_EL_SR;
                end
                S_EL_SR:
                begin
                    fault_reg       <= fault_reg | mul_s.ovf | sub_s.ovf;
                    rows_loaded_reg <= rows_loaded_reg + 1'b1;
                    if (last_reg)
                    begin
                        top_reg   <= rows_loaded_reg[tss_pkg::ADDR_W-1:0];
                        idx_reg   <= rows_loaded_reg[tss_pkg::ADDR_W-1:0];
                        state_reg <= S_BS_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_BS_RD:
                begin
                    state_reg <= S_BS_CAP;
                end
                S_BS_CAP:
                begin
                    up_reg  <= row_rdata_reg.upper;
                    piv_reg <= row_rdata_reg.pivot;
                    rh_reg  <= row_rdata_reg.rhs;
                    s_reg   <= row_rdata_reg.rhs;
                    // The bottom row divides its right-hand side directly.
                    state_reg <= (idx_reg == top_reg) ? S_BS_GO : S_BS_MUL;
                end
                S_BS_MUL:
                begin
                    prod_reg  <= 64'(up_reg) * 64'(xprev_reg);
                    state_reg <= S_BS_SUB;
                end
                S_BS_SUB:
                begin
                    s_reg     <= sub_s.val;
                    fault_reg <= fault_reg | mul_s.ovf | sub_s.ovf;
                    state_reg <= S_BS_GO;
                end
                S_BS_GO:
                begin
                    state_reg <= S_BS_DIV;
                end
                S_BS_DIV:
                begin
                    if (div_res.done)
                    begin
                        xprev_reg <= div_res.quot;
                        fault_reg <= fault_reg | div_res.fault;
                        if (idx_reg == '0)
                        begin
                            idx_reg   <= top_reg;
                            state_reg <= S_EM_RD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= S_BS_RD;
                        end
                    end
                end
                S_EM_RD:
                begin
                    state_reg <= S_EM_LD;
                end
                S_EM_LD:
                begin
                    solution_reg   <= x_rdata_reg;
                    row_number_reg <= idx_reg;
                    final_item_reg <= (idx_reg == '0);
                    fault_out_reg  <= fault_reg;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= S_EM_OUT;
                end
                S_EM_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (idx_reg == '0)
                        begin
                            rows_loaded_reg <= '0;
                            fault_reg       <= 1'b0;
                            state_reg       <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= S_EM_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign solution   = solution_reg;
    assign row_number = row_number_reg;
    assign final_item = final_item_reg;
    assign fault      = fault_out_reg;

    // A result is only ever presented from the emit hold state.
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_EM_OUT))
        else $error("result presented outside the emit state");

    // The stored row count never exceeds the memory capacity.
    a_rows_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rows_loaded_reg <= tss_pkg::CNT_W'(tss_pkg::MAX_ROWS))
        else $error("row count beyond capacity");

    // Delivering row 0 ends the run and clears the run state.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EM_OUT && !out_stall && idx_reg == '0)
        |=> (rows_loaded_reg == '0 && !fault_reg && state_reg == S_IDLE))
        else $error("run state not cleared after final result");

endmodule

// ----- test/tss_solution_checker.sv -----
// Solution checker for the tridiagonal solver: predicts solution elements and compares them.
`timescale 1ns / 1ps

module tss_solution_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] sub_diag,
    input  logic signed [31:0] main_diag,
    input  logic signed [31:0] super_diag,
    input  logic signed [31:0] rhs_value,
    input  logic               last_row,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] solution,
    input  logic [5:0]         row_number,
    input  logic               final_item,
    input  logic               fault,
    output int                 error_count,
    output int                 pending_count
);

    typedef struct {
        tss_pkg::q_t x;
        logic [5:0]  row;
        logic        fin;
        logic        flt;
    } sol_t;

    tss_pkg::q_t upper_mem [tss_pkg::DEPTH];
    tss_pkg::q_t pivot_mem [tss_pkg::DEPTH];
    tss_pkg::q_t rhs_mem   [tss_pkg::DEPTH];
    int          stored_rows;
    bit          fault_flag;
    sol_t        solution_queue [$];

    function automatic tss_pkg::q_t clamp(input longint v);
        if (v > longint'(tss_pkg::Q_MAX))
        begin
            fault_flag = 1;
            return tss_pkg::Q_MAX;
        end
        if (v < longint'(tss_pkg::Q_MIN))
        begin
            fault_flag = 1;
            return tss_pkg::Q_MIN;
        end
        return tss_pkg::q_t'(v);
    endfunction

    // Floor of the product over 2^FRAC_BITS; an arithmetic shift rounds towards minus infinity.
    function automatic tss_pkg::q_t fx_mul(input tss_pkg::q_t a, input tss_pkg::q_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp(p >>> tss_pkg::FRAC_BITS);
    endfunction

    function automatic tss_pkg::q_t fx_div(input tss_pkg::q_t a, input tss_pkg::q_t b);
        longint num;
        if (b == 0)
        begin
            fault_flag = 1;
            return (a >= 0) ? tss_pkg::Q_MAX : tss_pkg::Q_MIN;
        end
        num = longint'(a) * (64'sd1 <<< tss_pkg::FRAC_BITS);
        return clamp(num / longint'(b));
    endfunction

    function automatic tss_pkg::q_t fx_sub(input tss_pkg::q_t a, input tss_pkg::q_t b);
        return clamp(longint'(a) - longint'(b));
    endfunction

    task automatic eliminate_row(input tss_pkg::q_t a, b, c, d, input bit fin);
        tss_pkg::q_t k;
        tss_pkg::q_t xs [tss_pkg::DEPTH];
        int          n;
        sol_t        s;
        if (stored_rows >= tss_pkg::MAX_ROWS)
            fault_flag = 1;
        else
        begin
            if (stored_rows == 0)
            begin
                pivot_mem[0] = b;
                rhs_mem[0]   = d;
            end
            else
            begin
                k = fx_div(a, pivot_mem[stored_rows-1]);
                pivot_mem[stored_rows] = fx_sub(b, fx_mul(k, upper_mem[stored_rows-1]));
                rhs_mem[stored_rows]   = fx_sub(d, fx_mul(k, rhs_mem[stored_rows-1]));
            end
            upper_mem[stored_rows] = c;
            stored_rows++;
        end
        if (!fin) return;
        n = stored_rows;
        xs[n-1] = fx_div(rhs_mem[n-1], pivot_mem[n-1]);
        for (int i = n - 1; i >= 1; i--)
            xs[i-1] = fx_div(fx_sub(rhs_mem[i-1], fx_mul(upper_mem[i-1], xs[i])),
                             pivot_mem[i-1]);
        for (int r = n - 1; r >= 0; r--)
        begin
            s.x = xs[r];
            s.row = r[5:0];
            s.fin = (r == 0);
            s.flt = fault_flag;
            solution_queue.push_back(s);
        end
        stored_rows = 0;
        fault_flag  = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sol_t e;
        if (!rst_n)
        begin
            stored_rows = 0;
            fault_flag  = 0;
            error_count = 0;
            solution_queue.delete();
            pending_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                eliminate_row(sub_diag, main_diag, super_diag, rhs_value, last_row);
            if (out_valid && !out_stall)
            begin
                if (solution_queue.size() == 0)
                begin
                    $error("unexpected solution transaction, row %0d", row_number);
                    error_count++;
                end
                else
                begin
                    e = solution_queue.pop_front();
                    if (solution !== e.x)
                    begin
                        $error("solution: expected %0d, got %0d", e.x, solution);
                        error_count++;
                    end
                    if (row_number !== e.row)
                    begin
                        $error("row_number: expected %0d, got %0d", e.row, row_number);
                        error_count++;
                    end
                    if (final_item !== e.fin)
                    begin
                        $error("final_item: expected %0b, got %0b", e.fin, final_item);
                        error_count++;
                    end
                    if (fault !== e.flt)
                    begin
                        $error("fault: expected %0b, got %0b", e.flt, fault);
                        error_count++;
                    end
                end
            end
            pending_count = solution_queue.size();
        end
    end

endmodule

// ----- test/tb_tridiagonal_system_solver_unit.sv -----
// Top of the tridiagonal solver testbench: stimulus, idling phases and the verdict.
`timescale 1ns / 1ps

module tb_tridiagonal_system_solver_unit;

    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    tss_pkg::q_t sub_diag = '0;
    tss_pkg::q_t main_diag = '0;
    tss_pkg::q_t super_diag = '0;
    tss_pkg::q_t rhs_value = '0;
    logic        last_row = 0;
    logic        out_valid;
    logic        out_stall = 0;
    tss_pkg::q_t solution;
    logic [5:0]  row_number;
    logic        final_item;
    logic        fault;
    int          error_count;
    int          pending_count;

    // Percentages of cycles in which each side idles; changed between phases.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    // While set, the receiver stalls regardless of its percentage.
    bit          hold_off = 0;
    longint      cycle_count = 0;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    tridiagonal_system_solver_unit u_dut (.*);

    tss_solution_checker u_checker (.*);

    // The receiver decides afresh each cycle whether to stall.
    always @(posedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // A watchdog bounds the run even if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one row and holds it until the block accepts the transaction.
    // The stall is looked at mid-cycle, so it is the value seen at the next rising edge.
    task automatic send_row(input tss_pkg::q_t a, b, c, d, input bit fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid   <= 1;
        sub_diag   <= a;
        main_diag  <= b;
        super_diag <= c;
        rhs_value  <= d;
        last_row   <= fin;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic tss_pkg::q_t random_q();
        case ($urandom_range(5))
            0: return tss_pkg::q_t'($urandom);
            1: return tss_pkg::Q_MAX;
            2: return tss_pkg::Q_MIN;
            3: return 0;
            default: return tss_pkg::q_t'($signed($urandom_range(32'h0800_0000))
                                          - 32'sh0400_0000);
        endcase
    endfunction

    // A mostly diagonally dominant system keeps the solution well inside range,
    // while the occasional random row reaches the saturating and zero pivot paths.
    task automatic send_system(input int rows);
        tss_pkg::q_t a, b, c, d;
        for (int i = 0; i < rows; i++)
        begin
            a = tss_pkg::q_t'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
            c = tss_pkg::q_t'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
            b = tss_pkg::q_t'(32'sh0300_0000 + $urandom_range(32'h0400_0000));
            if ($urandom_range(1)) b = -b;
            d = tss_pkg::q_t'($urandom);
            if ($urandom_range(9) == 0)
            begin
                a = random_q(); b = random_q(); c = random_q(); d = random_q();
            end
            send_row(a, b, c, d, i == rows - 1);
        end
    endtask

    // Waits for every expected solution, then for the tail of the block's work.
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_phase(input int p);
        case (p)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 83;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 83;
            end
            default:
            begin
                send_idle_pct = 8;
                recv_stall_pct = 8;
            end
        endcase
    endtask

    initial
    begin
        int sent;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: a one-row system, a zero pivot, extreme values and overflow.
        send_row(0, 32'sh0100_0000, 0, 32'sh0200_0000, 1);
        send_row(0, 0, 0, 32'sh0100_0000, 1);
        send_row(0, 0, 0, -32'sh0100_0000, 1);
        send_row(tss_pkg::Q_MAX, 32'sh0000_0001, tss_pkg::Q_MIN, tss_pkg::Q_MAX, 1);
        send_row(tss_pkg::Q_MIN, tss_pkg::Q_MIN, tss_pkg::Q_MAX, tss_pkg::Q_MIN, 0);
        send_row(tss_pkg::Q_MAX, tss_pkg::Q_MAX, tss_pkg::Q_MIN, tss_pkg::Q_MAX, 0);
        send_row(32'sh0100_0000, 0, tss_pkg::Q_MAX, tss_pkg::Q_MIN, 1);
        send_row(-1, 32'sh0200_0000, -1, -1, 0);
        send_row(-1, 32'sh0200_0000, 32'sh0100_0000, 32'sh0300_0000, 0);
        send_row(32'sh0100_0000, -32'sh0200_0000, 0, 0, 1);
        drain();

        // Too many rows: the block holds 64, and rows beyond that raise the fault flag.
        // During this system the receiver holds off long enough for the block to fill,
        // and the sender keeps offering the next system while results are held back.
        set_phase(3);
        fork
        begin
            hold_off = 1;
            repeat (20000) @(posedge clk);
            hold_off = 0;
        end
        begin
            send_system(tss_pkg::MAX_ROWS + 2);
            send_system(3);
        end
        join
        drain();

        // Random part: systems of mostly small sizes through all the idling phases.
        sent = 0;
        for (int p = 0; sent < 130; p++)
        begin
            set_phase(p % 4);
            for (int s = 0; s < 4; s++)
            begin
                int rows;
                rows = ($urandom_range(9) == 0) ? $urandom_range(tss_pkg::MAX_ROWS, 20)
                                                : $urandom_range(6, 1);
                send_system(rows);
                sent += rows;
            end
            drain();
        end

        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tss_pkg.sv
src/tss_div.sv
src/tridiagonal_system_solver_unit.sv
test/tss_solution_checker.sv
test/tb_tridiagonal_system_solver_unit.sv
